// File: hw/rtl/pps_period_pid_discipline_defines.svh
// assertion macros shared by the pps period discipline rtl
// expects clk and rst (synchronous, active high) in the including module
`ifndef PPS_PERIOD_PID_DISCIPLINE_DEFINES_SVH
`define PPS_PERIOD_PID_DISCIPLINE_DEFINES_SVH

// checked on every edge outside reset
`define PPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ppd_pkg.sv
// types, constants and the microcode table of the pps period discipline
// no dependencies; imported by ppd_divider and pps_period_pid_discipline
`default_nettype none

package ppd_pkg;

  localparam int ERR_W    = 32;  // phase error, error sum
  localparam int DIFF_W   = 33;  // exact error difference
  localparam int DIV_W    = 16;  // divisor registers
  localparam int QUOT_W   = 34;  // signed quotient
  localparam int ACC_W    = 35;  // sum of the three quotients
  localparam int PERIOD_W = 31;  // reload period
  localparam int CNT_W    = 8;   // sample count, warm-up count
  localparam int IDX_W    = 2;   // register index

  typedef enum logic [IDX_W-1:0] {
    REG_DERIV_DIV = 2'd0,
    REG_PROP_DIV  = 2'd1,
    REG_INTEG_DIV = 2'd2,
    REG_WARMUP    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_UPDATE,
    OP_START,
    OP_ACC,
    OP_APPLY,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SEL_DIFF,
    SEL_ERR,
    SEL_SUM
  } opnd_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_NOT_TUNE,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_ACCEPT = 4'd0;
  localparam pc_t PC_UPDATE = 4'd1;
  localparam pc_t PC_CHECK  = 4'd2;
  localparam pc_t PC_START0 = 4'd3;
  localparam pc_t PC_ACC0   = 4'd4;
  localparam pc_t PC_START1 = 4'd5;
  localparam pc_t PC_ACC1   = 4'd6;
  localparam pc_t PC_START2 = 4'd7;
  localparam pc_t PC_ACC2   = 4'd8;
  localparam pc_t PC_APPLY  = 4'd9;
  localparam pc_t PC_EMIT   = 4'd10;
  localparam pc_t PC_WRAP   = 4'd11;

  typedef struct packed {
    op_t   op;
    opnd_t sel;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] num;
    logic [DIV_W-1:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;

  function automatic ucode_t uw(input op_t op, input opnd_t sel, input cond_t cond,
                                input pc_t target);
    ucode_t w;
    w.op     = op;
    w.sel    = sel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // the program: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_ACCEPT: w = uw(OP_ACCEPT, SEL_DIFF, COND_NO_INPUT, PC_ACCEPT);
      PC_UPDATE: w = uw(OP_UPDATE, SEL_DIFF, COND_NEVER,    PC_ACCEPT);
      PC_CHECK:  w = uw(OP_NOP,    SEL_DIFF, COND_NOT_TUNE, PC_EMIT);
      PC_START0: w = uw(OP_START,  SEL_DIFF, COND_NEVER,    PC_ACCEPT);
      PC_ACC0:   w = uw(OP_ACC,    SEL_DIFF, COND_DIV_BUSY, PC_ACC0);
      PC_START1: w = uw(OP_START,  SEL_ERR,  COND_NEVER,    PC_ACCEPT);
      PC_ACC1:   w = uw(OP_ACC,    SEL_ERR,  COND_DIV_BUSY, PC_ACC1);
      PC_START2: w = uw(OP_START,  SEL_SUM,  COND_NEVER,    PC_ACCEPT);
      PC_ACC2:   w = uw(OP_ACC,    SEL_SUM,  COND_DIV_BUSY, PC_ACC2);
      PC_APPLY:  w = uw(OP_APPLY,  SEL_DIFF, COND_NEVER,    PC_ACCEPT);
      PC_EMIT:   w = uw(OP_EMIT,   SEL_DIFF, COND_OUT_FULL, PC_EMIT);
      PC_WRAP:   w = uw(OP_NOP,    SEL_DIFF, COND_ALWAYS,   PC_ACCEPT);
      default:   w = uw(OP_NOP,    SEL_DIFF, COND_ALWAYS,   PC_ACCEPT);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ppd_divider.sv
// iterative signed-by-unsigned divider, four quotient bits per cycle
// depends on ppd_pkg; quotient truncates toward zero, zero divisor gives zero
`default_nettype none

module ppd_divider (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ppd_pkg::div_req_t req,
  output ppd_pkg::div_rsp_t    rsp
);
  import ppd_pkg::*;

  localparam int RADIX_BITS = 4;
  localparam int ITER       = (DIFF_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int WORK_W     = ITER * RADIX_BITS;
  localparam int STEP_W     = $clog2(ITER + 1);

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic [WORK_W-1:0]   work, work_next;
  logic [DIV_W-1:0]    rem, rem_next;
  logic [DIV_W-1:0]    den;
  logic                neg;
  logic                den_zero;
  logic [DIFF_W-1:0]   num_mag;
  logic [DIV_W:0]      trial;
  logic signed [QUOT_W-1:0] qpos;

  assign num_mag = req.num[DIFF_W-1] ? DIFF_W'(-req.num) : DIFF_W'(req.num);

  // restoring division, RADIX_BITS dividend bits per cycle
  always_comb begin
    rem_next  = rem;
    work_next = work;
    trial     = '0;
    for (int k = 0; k < RADIX_BITS; k++) begin
      trial     = {rem_next, work_next[WORK_W-1]};
      work_next = {work_next[WORK_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial        = trial - {1'b0, den};
        work_next[0] = 1'b1;
      end
      rem_next = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= STEP_W'(ITER);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work     <= {{(WORK_W-DIFF_W){1'b0}}, num_mag};
      rem      <= '0;
      den      <= req.den;
      neg      <= req.num[DIFF_W-1];
      den_zero <= (req.den == '0);
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign qpos      = $signed({1'b0, work[DIFF_W-1:0]});
  assign rsp.busy  = busy;
  assign rsp.quot  = den_zero ? '0 : (neg ? -qpos : qpos);

endmodule

`default_nettype wire

// File: hw/rtl/pps_period_pid_discipline.sv
// top level of the pps period discipline: pid trim of a one-second reload period
// depends on ppd_pkg, ppd_divider and pps_period_pid_discipline_defines.svh
`default_nettype none
`include "pps_period_pid_discipline_defines.svh"

// One request on the slave stream is one phase error sample taken at a
// one-second alarm. The block folds it into a saturating error sum, forms
// the exact difference from the previous sample and counts samples up to
// warmup_count. Once the count has reached warmup_count it adds
// diff/deriv_divisor + err/prop_divisor + sum/integ_divisor (each quotient
// truncated toward zero, a zero divisor giving zero) to the reload period,
// clamped to 0 .. 2^31-1, and marks the result as tuned in tuser. Every
// sample yields exactly one result request. Control is a twelve-step
// microprogram; the three quotients share one divider that retires four
// quotient bits per cycle; each quotient takes one start step and then an
// accumulate step that waits on the divider. A tuned sample passes through
// all three quotients before it is offered as a result, a warm-up sample
// goes from the check step straight to the emit step; the wrap step then
// returns to the accept step, so the next sample is taken only after the
// previous one has reached the emit step. A result waits in an output
// register while the next sample is accepted and processed; if it is still
// waiting when the next result is ready, the emit step stalls. No sample
// is taken during reset. Configuration writes land at once and should be
// made only while no sample is in flight.
module pps_period_pid_discipline #(
  parameter int NOMINAL_PERIOD = 1000000
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // sample stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [ppd_pkg::ERR_W-1:0]    s_axis_tdata,   // [31:0] phase_error
  // result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [63:0]                       m_axis_tdata,   // [30:0] reload_period,
                                                            // [62:31] error_integral,
                                                            // [63] zero
  output logic                              m_axis_tuser,   // [0] tuning_applied
  // configuration writes
  input  wire logic                         cfg_we,
  input  wire logic [ppd_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [ppd_pkg::DIV_W-1:0]    cfg_wdata
);
  import ppd_pkg::*;

  localparam logic signed [ERR_W-1:0] SUM_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] SUM_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // configuration registers
  logic [DIV_W-1:0] deriv_div, prop_div, integ_div;
  logic [CNT_W-1:0] warmup;

  // sequencer
  pc_t    pc, pc_next;
  ucode_t ctl;
  logic   cond_hit;

  // datapath
  logic signed [ERR_W-1:0]  err_in;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [ERR_W-1:0]  err_sum, err_sum_next;
  logic signed [ERR_W:0]    sum_wide;
  logic signed [DIFF_W-1:0] diff;
  logic [CNT_W-1:0]         sample_count, sample_count_next;
  logic                     tune;
  logic signed [ACC_W-1:0]  acc;
  logic [PERIOD_W-1:0]      period, period_next;
  logic signed [ACC_W:0]    per_wide;

  // output register
  logic [PERIOD_W-1:0]      out_period;
  logic                     out_tune;
  logic signed [ERR_W-1:0]  out_sum;
  logic                     out_full;

  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      deriv_div <= DIV_W'(1);
      prop_div  <= DIV_W'(1);
      integ_div <= DIV_W'(1);
      warmup    <= CNT_W'(2);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DERIV_DIV: deriv_div <= cfg_wdata;
        REG_PROP_DIV:  prop_div  <= cfg_wdata;
        REG_INTEG_DIV: integ_div <= cfg_wdata;
        REG_WARMUP:    warmup    <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // microprogram fetch and branch
  assign ctl      = ucode_rom(pc);
  assign out_full = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    case (ctl.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_INPUT: cond_hit = !s_axis_tvalid;
      COND_NOT_TUNE: cond_hit = !tune;
      COND_DIV_BUSY: cond_hit = div_rsp.busy;
      COND_OUT_FULL: cond_hit = out_full;
      default:       cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? ctl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

  assign s_axis_tready = (ctl.op == OP_ACCEPT) && !rst;

  // saturating error sum and warm-up count
  assign sum_wide = {err_sum[ERR_W-1], err_sum} + {err_in[ERR_W-1], err_in};

  always_comb begin
    if (sum_wide[ERR_W] != sum_wide[ERR_W-1]) begin
      err_sum_next = sum_wide[ERR_W] ? SUM_MIN : SUM_MAX;
    end else begin
      err_sum_next = sum_wide[ERR_W-1:0];
    end
    sample_count_next = (sample_count < warmup) ? sample_count + 1'b1 : sample_count;
  end

  // period plus the summed quotients, clamped to the 31-bit range
  assign per_wide = $signed({{(ACC_W+1-PERIOD_W){1'b0}}, period}) + {acc[ACC_W-1], acc};

  always_comb begin
    if (per_wide[ACC_W]) begin
      period_next = '0;
    end else if (|per_wide[ACC_W-1:PERIOD_W]) begin
      period_next = '1;
    end else begin
      period_next = per_wide[PERIOD_W-1:0];
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      prev_err     <= '0;
      err_sum      <= '0;
      period       <= PERIOD_W'(NOMINAL_PERIOD);
      tune         <= 1'b0;
    end else begin
      case (ctl.op)
        OP_UPDATE: begin
          sample_count <= sample_count_next;
          tune         <= (sample_count_next >= warmup);
          err_sum      <= err_sum_next;
          prev_err     <= err_in;
        end
        OP_APPLY: period <= period_next;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_ACCEPT: begin
        if (s_axis_tvalid) begin
          err_in <= s_axis_tdata;
        end
      end
      OP_UPDATE: begin
        diff <= {err_in[ERR_W-1], err_in} - {prev_err[ERR_W-1], prev_err};
        acc  <= '0;
      end
      OP_ACC: begin
        if (!div_rsp.busy) begin
          acc <= acc + {div_rsp.quot[QUOT_W-1], div_rsp.quot};
        end
      end
      default: ;
    endcase
  end

  // divider operand select
  always_comb begin
    div_req.start = (ctl.op == OP_START);
    case (ctl.sel)
      SEL_DIFF: begin
        div_req.num = diff;
        div_req.den = deriv_div;
      end
      SEL_ERR: begin
        div_req.num = {err_in[ERR_W-1], err_in};
        div_req.den = prop_div;
      end
      SEL_SUM: begin
        div_req.num = {err_sum[ERR_W-1], err_sum};
        div_req.den = integ_div;
      end
      default: begin
        div_req.num = diff;
        div_req.den = deriv_div;
      end
    endcase
  end

  ppd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.op == OP_EMIT && !out_full) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT && !out_full) begin
      out_period <= period;
      out_tune   <= tune;
      out_sum    <= err_sum;
    end
  end

  assign m_axis_tdata = {1'b0, out_sum, out_period};
  assign m_axis_tuser = out_tune;

  // a sample is taken only while the divider is idle
  `PPD_ASSERT(a_accept_div_idle, s_axis_tready |-> !div_rsp.busy, "sample accepted while dividing")
  // a division starts only on an idle divider and then reports busy
  `PPD_ASSERT(a_start_busy, div_req.start |=> div_rsp.busy, "divider not busy after start")
  // a new result appears only from the emit step
  `PPD_ASSERT(a_emit_source, $rose(m_axis_tvalid) |-> $past(ctl.op == OP_EMIT),
    "result raised outside emit step")
  // a tuned result implies the warm-up count was reached
  `PPD_ASSERT(a_tune_warm, m_axis_tvalid && m_axis_tuser |-> sample_count >= warmup,
    "tuned result before warm-up complete")

endmodule

`default_nettype wire
